/* rtl/core/qsud_pkg.sv */
`timescale 1ns / 1ps

package qsud_pkg;

    localparam logic [7:0] ESCAPE_RESET = 8'd17;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [1:0] DIGIT_BYTES  = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
    } out_t;

    function automatic logic [7:0] control_map(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h62, 8'h42: r = 8'h08;
            8'h6E, 8'h4E: r = 8'h0A;
            8'h72, 8'h52: r = 8'h0D;
            8'h74, 8'h54: r = 8'h09;
            8'h76, 8'h56: r = 8'h0B;
            8'h45:        r = 8'h1B;
            8'h46:        r = 8'h0C;
            default:      r = b;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/qsud_decoder.sv */
`timescale 1ns / 1ps

module qsud_decoder
    import qsud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  in_t        item,
    input  logic [7:0] escape_code,
    output logic       emit,
    output out_t       result
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_QUOTED = 3'd1,
        PH_ESC    = 3'd2,
        PH_DIGITS = 3'd3,
        PH_PLAIN  = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       dquote_reg, dquote_next;
    logic [1:0] digits_reg, digits_next;
    logic [7:0] octal_reg, octal_next;

    logic [7:0] b;
    logic       is_digit;
    logic [7:0] digit_val;
    logic [7:0] quote;
    logic [7:0] octal_acc;
    logic [1:0] digits_dec;

    assign b          = item.in_byte;
    assign is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit_val  = b - CH_ZERO;
    assign quote      = dquote_reg ? CH_DQUOTE : CH_SQUOTE;
    assign octal_acc  = is_digit ? ({octal_reg[4:0], 3'b000} + digit_val) : octal_reg;
    assign digits_dec = digits_reg - 2'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        dquote_next = dquote_reg;
        digits_next = digits_reg;
        octal_next  = octal_reg;
        emit        = 1'b0;
        result      = '{out_byte: CH_NUL, end_of_string: 1'b0};
        if (item.first_byte)
        begin
            digits_next = 2'd0;
            octal_next  = 8'd0;
            if (b == CH_DQUOTE || b == CH_SQUOTE)
            begin
                dquote_next = (b == CH_DQUOTE);
                phase_next  = PH_QUOTED;
            end
            else if (b == CH_NUL)
            begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                result     = '{out_byte: CH_NUL, end_of_string: 1'b1};
            end
            else
            begin
                phase_next = PH_PLAIN;
                emit       = 1'b1;
                result     = '{out_byte: b, end_of_string: 1'b0};
            end
        end
        else
        begin
            case (phase_reg)
                PH_PLAIN:
                begin
                    emit   = 1'b1;
                    result = '{out_byte: b, end_of_string: (b == CH_NUL)};
                    if (b == CH_NUL)
                    begin
                        phase_next  = PH_IDLE;
                        digits_next = 2'd0;
                        octal_next  = 8'd0;
                    end
                end
                PH_QUOTED:
                begin
                    if (b == CH_NUL || b == quote)
                    begin
                        phase_next  = PH_IDLE;
                        digits_next = 2'd0;
                        octal_next  = 8'd0;
                        emit        = 1'b1;
                        result      = '{out_byte: CH_NUL, end_of_string: 1'b1};
                    end
                    else if (b == escape_code)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        emit   = 1'b1;
                        result = '{out_byte: b, end_of_string: 1'b0};
                    end
                end
                PH_ESC:
                begin
                    if (b == CH_NUL)
                    begin
                        phase_next  = PH_IDLE;
                        digits_next = 2'd0;
                        octal_next  = 8'd0;
                        emit        = 1'b1;
                        result      = '{out_byte: CH_NUL, end_of_string: 1'b1};
                    end
                    else if (is_digit)
                    begin
                        octal_next  = digit_val;
                        digits_next = DIGIT_BYTES - 2'd1;
                        phase_next  = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_QUOTED;
                        emit       = 1'b1;
                        result     = '{out_byte: control_map(b), end_of_string: 1'b0};
                    end
                end
                PH_DIGITS:
                begin
                    if (b == CH_NUL)
                    begin
                        phase_next  = PH_IDLE;
                        digits_next = 2'd0;
                        octal_next  = 8'd0;
                        emit        = 1'b1;
                        result      = '{out_byte: CH_NUL, end_of_string: 1'b1};
                    end
                    else
                    begin
                        octal_next  = octal_acc;
                        digits_next = digits_dec;
                        if (digits_dec == 2'd0)
                        begin
                            phase_next = PH_QUOTED;
                            emit       = 1'b1;
                            result     = '{out_byte: octal_acc, end_of_string: 1'b0};
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            dquote_reg <= 1'b0;
            digits_reg <= 2'd0;
            octal_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            dquote_reg <= dquote_next;
            digits_reg <= digits_next;
            octal_reg  <= octal_next;
        end
    end

endmodule

/* rtl/core/quoted_string_unquote_decoder_top.sv */
`timescale 1ns / 1ps

// quoted-string unquote decoder
// in channel: in_valid / in_ready carry one source byte per item, with
//   first_byte set on the first byte of each string
// out channel: out_valid / out_ready carry one decoded byte per item;
//   end_of_string marks the closing terminator
// cfg channel: cfg_valid / cfg_ready write the escape code (cfg_ready is always
//   high); the user writes only while the block is idle; this is not enforced
// path: an accepted item that gives a result goes through the input register,
//   then the result register, before it shows on out_valid
// throughput: one item per cycle while out_ready does not hold the result
//   register, set by the state update in the decoder between the two registers
// an item that gives no result (opening quote, escape lead-in, digit bytes
//   before the last, bytes after the end) just leaves the result register empty
// stall: while out_valid waits for out_ready, the input register holds and
//   in_ready stays high until it is full
// reset: escape code returns to 17, the decoder goes idle and both
//   registers empty

module quoted_string_unquote_decoder_top
    import qsud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] escape_reg;
    logic       s1_valid_reg;
    in_t        s1_item_reg;
    logic       out_valid_reg;
    out_t       out_item_reg;

    logic       s1_step;
    logic       dec_emit;
    out_t       dec_result;

    assign cfg_ready = 1'b1;
    assign s1_step   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_step;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    qsud_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_step),
        .item        (s1_item_reg),
        .escape_code (escape_reg),
        .emit        (dec_emit),
        .result      (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg    <= ESCAPE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                escape_reg <= cfg_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_step)
            begin
                out_valid_reg <= dec_emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_step && dec_emit)
        begin
            out_item_reg <= dec_result;
        end
    end

endmodule

/* test/quoted_string_unquote_decoder_top_test.sv */
`timescale 1ns / 1ps

module quoted_string_unquote_decoder_top_test;

    import qsud_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'd0,
        ST_QUOTED = 3'd1,
        ST_ESCAPE = 3'd2,
        ST_DIGITS = 3'd3,
        ST_PLAIN  = 3'd4
    } scan_state_t;

    localparam int PHASE_ITEMS = 115;
    localparam int WARM_ITEMS  = 28;
    localparam logic [8*12-1:0] LETTERS = "bBnNrRtTvVEF";

    class unquote_scoreboard;
        scan_state_t state;
        logic        dq_open;
        logic [1:0]  digits_owed;
        logic [7:0]  octal_acc;
        logic [7:0]  escape_byte;
        out_t        expected_bytes[$];
        int          errors;

        function new();
            state       = ST_IDLE;
            dq_open     = 1'b0;
            digits_owed = 2'd0;
            octal_acc   = 8'd0;
            escape_byte = ESCAPE_RESET;
            errors      = 0;
        endfunction

        function logic [7:0] control_letter(input logic [7:0] b);
            logic [7:0] r;
            case (b)
                "b", "B": r = 8'h08;
                "n", "N": r = 8'h0A;
                "r", "R": r = 8'h0D;
                "t", "T": r = 8'h09;
                "v", "V": r = 8'h0B;
                "E":      r = 8'h1B;
                "F":      r = 8'h0C;
                default:  r = b;
            endcase
            return r;
        endfunction

        function void push_byte(input logic [7:0] b, input logic eos);
            out_t r;
            r.out_byte      = b;
            r.end_of_string = eos;
            expected_bytes.push_back(r);
        endfunction

        function void close_string();
            state       = ST_IDLE;
            digits_owed = 2'd0;
            octal_acc   = 8'd0;
            push_byte(CH_NUL, 1'b1);
        endfunction

        // returns 1 when the item is dropped
        function bit decode_byte(input in_t it);
            logic [7:0] b;
            logic       is_digit;
            logic [7:0] quote;
            b        = it.in_byte;
            is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
            quote    = dq_open ? CH_DQUOTE : CH_SQUOTE;
            if (it.first_byte)
            begin
                digits_owed = 2'd0;
                octal_acc   = 8'd0;
                if (b == CH_DQUOTE || b == CH_SQUOTE)
                begin
                    dq_open = (b == CH_DQUOTE);
                    state   = ST_QUOTED;
                end
                else if (b == CH_NUL)
                begin
                    close_string();
                end
                else
                begin
                    state = ST_PLAIN;
                    push_byte(b, 1'b0);
                end
                return 1'b0;
            end
            case (state)
                ST_PLAIN:
                begin
                    if (b == CH_NUL)
                        close_string();
                    else
                        push_byte(b, 1'b0);
                end
                ST_QUOTED:
                begin
                    if (b == CH_NUL || b == quote)
                        close_string();
                    else if (b == escape_byte)
                        state = ST_ESCAPE;
                    else
                        push_byte(b, 1'b0);
                end
                ST_ESCAPE:
                begin
                    if (b == CH_NUL)
                    begin
                        close_string();
                    end
                    else if (is_digit)
                    begin
                        octal_acc   = b - CH_ZERO;
                        digits_owed = 2'd2;
                        state       = ST_DIGITS;
                    end
                    else
                    begin
                        state = ST_QUOTED;
                        push_byte(control_letter(b), 1'b0);
                    end
                end
                ST_DIGITS:
                begin
                    if (b == CH_NUL)
                    begin
                        close_string();
                    end
                    else
                    begin
                        if (is_digit)
                            octal_acc = (octal_acc << 3) + (b - CH_ZERO);
                        digits_owed = digits_owed - 2'd1;
                        if (digits_owed == 2'd0)
                        begin
                            state = ST_QUOTED;
                            push_byte(octal_acc, 1'b0);
                        end
                    end
                end
                default:
                    return 1'b1;
            endcase
            return 1'b0;
        endfunction

        function void check_decoded(input out_t got);
            out_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("out_item: no item expected, got out_byte %0h end_of_string %0b",
                       got.out_byte, got.end_of_string);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.end_of_string !== want.end_of_string)
            begin
                $error("end_of_string: expected %0b, got %0b",
                       want.end_of_string, got.end_of_string);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_t        in_item;
    logic       out_valid;
    logic       out_ready;
    out_t       out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    unquote_scoreboard sb;
    int                items_taken = 0;
    bit                calm = 1'b0;

    // esc is 17 after reset
    logic [8:0] warmup [WARM_ITEMS] = '{
        {8'h00, 1'b1}, {8'hFF, 1'b1}, {8'h01, 1'b0}, {8'h00, 1'b0}, {8'h41, 1'b0},
        {8'h22, 1'b1}, {8'h27, 1'b0}, {8'h11, 1'b0}, {"n",   1'b0},
        {8'h11, 1'b0}, {"7",   1'b0}, {"7",   1'b0}, {"7",   1'b0},
        {8'h11, 1'b0}, {"0",   1'b0}, {8'h22, 1'b0}, {"0",   1'b0},
        {8'h11, 1'b0}, {"E",   1'b0}, {8'h11, 1'b0}, {8'h00, 1'b0},
        {8'h27, 1'b1}, {8'h11, 1'b0}, {"1",   1'b0}, {8'h00, 1'b0},
        {8'h27, 1'b1}, {8'h22, 1'b1}, {8'h22, 1'b0}
    };

    quoted_string_unquote_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_decoded(out_item);
    end

    initial
    begin
        int stall;
        stall = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall == 0 && !calm && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 18);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic first);
        in_t it;
        it.in_byte    = b;
        it.first_byte = first;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        if (!sb.decode_byte(it))
            items_taken++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_escape(input logic [7:0] code);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.escape_byte = code;
    endtask

    function automatic logic [7:0] text_byte(input logic [7:0] quote, input logic [7:0] esc);
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == quote || b == esc);
        return b;
    endfunction

    function automatic logic [7:0] escape_letter();
        if ($urandom_range(0, 9) < 7)
            return LETTERS[8 * $urandom_range(0, 11) +: 8];
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] digit_slot();
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom_range(CH_ZERO, CH_NINE));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_quoted();
        logic [7:0] quote;
        logic [7:0] esc;
        int         n;
        int         kind;
        int         ending;
        quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        esc   = sb.escape_byte;
        n     = $urandom_range(0, 10);
        send_item(quote, 1'b1);
        for (int k = 0; k < n; k++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                send_item(text_byte(quote, esc), 1'b0);
            end
            else if (kind < 7)
            begin
                send_item(esc, 1'b0);
                send_item(escape_letter(), 1'b0);
            end
            else
            begin
                send_item(esc, 1'b0);
                send_item(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
                for (int j = 0; j < 2; j++)
                    send_item(digit_slot(), 1'b0);
            end
        end
        ending = $urandom_range(0, 19);
        if (ending < 14)
        begin
            send_item(quote, 1'b0);
        end
        else if (ending < 17)
        begin
            send_item(CH_NUL, 1'b0);
        end
        else if (ending < 19)
        begin
            send_item(esc, 1'b0);
            if ($urandom_range(0, 1))
                send_item(digit_slot(), 1'b0);
            send_item(CH_NUL, 1'b0);
        end
        // otherwise the next string cuts this one off
        if ($urandom_range(0, 4) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_plain();
        logic [7:0] b;
        int         n;
        do b = 8'($urandom_range(1, 255)); while (b == CH_DQUOTE || b == CH_SQUOTE);
        n = $urandom_range(0, 10);
        send_item(b, 1'b1);
        for (int k = 0; k < n; k++)
            send_item(8'($urandom_range(1, 255)), 1'b0);
        if ($urandom_range(0, 5) != 0)
            send_item(CH_NUL, 1'b0);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(CH_NUL, $urandom_range(0, 5) == 0);
            else
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic run_strings(input int count);
        int target;
        int pick;
        target = items_taken + count;
        while (items_taken < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_quoted();
            else if (pick < 85)
                send_plain();
            else
                send_noise();
        end
    endtask

    initial
    begin
        logic [7:0] codes [8];
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'd0;
        codes = '{8'h5C, 8'h00, 8'hFF, CH_DQUOTE, CH_SQUOTE, CH_ZERO,
                  8'($urandom_range(0, 255)), ESCAPE_RESET};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < WARM_ITEMS; i++)
            send_item(warmup[i][8:1], warmup[i][0]);
        run_strings(PHASE_ITEMS);

        for (int p = 0; p < 8; p++)
        begin
            write_escape(codes[p]);
            if (p == 7)
                calm = 1'b1;
            run_strings(PHASE_ITEMS);
        end

        in_valid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.expected_bytes.size() != 0)
        begin
            $error("out_item: %0d items never arrived", sb.expected_bytes.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("quoted_string_unquote_decoder_top_test: done, clean");
        else
            $display("quoted_string_unquote_decoder_top_test: done, errors");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("quoted_string_unquote_decoder_top_test: done, errors");
        $finish;
    end

endmodule
